[hdl/bsp_pkg.sv]
package bsp_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int FRAME_BITS   = 24;
  localparam int FRAC_BITS    = 16;
  localparam int POS_BITS     = FRAME_BITS + FRAC_BITS;
  localparam int SEG_BITS     = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS     = SEG_BITS + 1;
  localparam int RATE_BITS    = 24;
  localparam int DUTY_BITS    = 17;
  localparam int DRAW_BITS    = 16;
  localparam int DIVR_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int DIV_W        = POS_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIV_W + 1);
  localparam int PROD_BITS    = 2 * RATE_BITS;

  localparam int RST_COUNT  = 8;
  localparam int RST_FRAMES = 65536;
  localparam int RST_SEGLEN = RST_FRAMES / RST_COUNT;
  localparam int RST_NB     = (2 * RST_FRAMES + RST_COUNT) / (2 * RST_COUNT);
  localparam int ONE_FX     = 1 << FRAC_BITS;
  localparam int MIN_DIVR   = 256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SEGMENT_COUNT = 2'd0,
    CFG_BUFFER_FRAMES = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                 op;
    logic [RATE_BITS-1:0] play_rate;
    logic [RATE_BITS-1:0] segment_speed;
    logic [DUTY_BITS-1:0] duty;
    logic [DUTY_BITS-1:0] jump_chance;
    logic [DUTY_BITS-1:0] stutter_chance;
    logic [DIVR_BITS-1:0] stutter_divisor;
    logic [DRAW_BITS-1:0] jump_draw;
    logic [DRAW_BITS-1:0] stutter_draw;
    logic [5:0]           jump_target;
    logic [5:0]           target_segment;
  } in_item_t;

  typedef struct packed {
    logic [23:0] read_address;
    logic [15:0] read_fraction;
    logic        gate_on;
    logic [5:0]  segment_now;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

[hdl/bsp_if.sv]
interface bsp_in_if;
  logic              valid;
  logic              ready;
  bsp_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bsp_out_if;
  logic               valid;
  logic               ready;
  bsp_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bsp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bsp_pkg::CFG_IDX_BITS-1:0]   index;
  logic [bsp_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/bsp_divider.sv]
module bsp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsp_pkg::div_req_t req_i,
  output bsp_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [bsp_pkg::DIV_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [bsp_pkg::DIV_W-1:0]         rem_q, rem_d;
  logic [bsp_pkg::DIV_W-1:0]         quo_q, quo_d;
  logic [bsp_pkg::DIV_W-1:0]         dsr_q, dsr_d;
  logic [bsp_pkg::DIV_W:0]           trial;
  logic [bsp_pkg::DIV_W:0]           diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[bsp_pkg::DIV_W-1]};
    diff   = trial - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = bsp_pkg::DIV_CNT_BITS'(bsp_pkg::DIV_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[bsp_pkg::DIV_W-1:0];
        quo_d = {quo_q[bsp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[bsp_pkg::DIV_W-1:0];
        quo_d = {quo_q[bsp_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == bsp_pkg::DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

[hdl/bsp_core.sv]
module bsp_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  bsp_pkg::in_item_t                 in_item_i,
  output logic                              in_ready_o,
  input  logic                              cfg_valid_i,
  input  logic [bsp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [bsp_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                              cfg_ready_o,
  output logic                              out_valid_o,
  output bsp_pkg::out_item_t                out_item_o,
  input  logic                              out_ready_i,
  output bsp_pkg::div_req_t                 div_req_o,
  input  bsp_pkg::div_rsp_t                 div_rsp_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_LA0, ST_LA, ST_LB, ST_W, ST_GATE, ST_ADV, ST_PMOD, ST_PFIN,
    ST_SEG, ST_SA, ST_SB, ST_SC, ST_SCD, ST_SD, ST_SE, ST_SF
  } state_e;

  localparam int FB = bsp_pkg::FRAME_BITS;
  localparam int PB = bsp_pkg::POS_BITS;
  localparam int DW = bsp_pkg::DIV_W;
  localparam int QB = bsp_pkg::FRAC_BITS;

  state_e                           state_q, state_d, ret_q, ret_d;
  bsp_pkg::div_req_t                req_q, req_d;
  bsp_pkg::in_item_t                item_q, item_d;
  bsp_pkg::out_item_t               out_q, out_d;
  logic                             out_valid_q, out_valid_d;
  logic [bsp_pkg::CNT_BITS-1:0]     count_q, count_d;
  logic [FB-1:0]                    frames_q, frames_d;
  logic [PB-1:0]                    play_q, play_d, slice_q, slice_d, w_q, w_d;
  logic [PB:0]                      sum_q, sum_d;
  logic [bsp_pkg::SEG_BITS-1:0]     cur_q, cur_d, idx_q, idx_d;
  logic                             trig_q, trig_d;
  logic [FB-1:0]                    start_q, start_d, nb_q, nb_d;
  logic [FB-1:0]                    slen_q, slen_d, seglen_q, seglen_d;
  logic [bsp_pkg::RATE_BITS-1:0]    speed_q, speed_d;
  logic [bsp_pkg::DUTY_BITS-1:0]    duty_q, duty_d;
  logic [bsp_pkg::PROD_BITS-1:0]    prod_q, prod_d;

  logic [bsp_pkg::CNT_BITS-1:0]     c_eff;
  logic [FB-1:0]                    f_eff;
  logic [bsp_pkg::SEG_BITS-1:0]     c_last, tgt;
  logic [FB:0]                      addr_sum;
  logic [PB:0]                      slice_sum;
  logic                             gate;
  logic                             do_jump, do_stut;
  logic [bsp_pkg::DIVR_BITS-1:0]    divr;
  logic [DW-1:0]                    off_dividend, off_divisor;

  always_comb begin
    c_eff = count_q;
    if (count_q == '0) begin
      c_eff = bsp_pkg::CNT_BITS'(1);
    end else if (count_q > bsp_pkg::CNT_BITS'(bsp_pkg::MAX_SEGMENTS)) begin
      c_eff = bsp_pkg::CNT_BITS'(bsp_pkg::MAX_SEGMENTS);
    end
    f_eff        = (frames_q == '0) ? FB'(1) : frames_q;
    c_last       = bsp_pkg::SEG_BITS'(c_eff - 1'b1);
    off_dividend = DW'({prod_q[FB+bsp_pkg::SEG_BITS-1:0], 1'b0}) + DW'(c_eff);
    off_divisor  = DW'({c_eff, 1'b0});
    do_jump      = {1'b0, item_q.jump_draw} < item_q.jump_chance;
    do_stut      = {1'b0, item_q.stutter_draw} < item_q.stutter_chance;
    divr         = (item_q.stutter_divisor < bsp_pkg::DIVR_BITS'(bsp_pkg::MIN_DIVR)) ?
                   bsp_pkg::DIVR_BITS'(bsp_pkg::MIN_DIVR) : item_q.stutter_divisor;
    tgt          = (item_q.jump_target > c_last) ? c_last : item_q.jump_target;
    gate         = duty_q[bsp_pkg::DUTY_BITS-1] || ({1'b0, w_q} < prod_q[PB:0]);
    addr_sum     = {1'b0, start_q} + {1'b0, w_q[PB-1:QB]};
    if (addr_sum >= {1'b0, f_eff}) begin
      addr_sum = addr_sum - {1'b0, f_eff};
    end
    slice_sum    = {1'b0, slice_q} + (PB+1)'(prod_q[bsp_pkg::PROD_BITS-1:QB]);
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    req_d       = req_q;
    req_d.start = 1'b0;
    item_d      = item_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;
    frames_d    = frames_q;
    play_d      = play_q;
    slice_d     = slice_q;
    w_d         = w_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    trig_d      = trig_q;
    start_d     = start_q;
    nb_d        = nb_q;
    slen_d      = slen_q;
    seglen_d    = seglen_q;
    speed_d     = speed_q;
    duty_d      = duty_q;
    prod_d      = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          case (cfg_index_i)
            bsp_pkg::CFG_SEGMENT_COUNT: begin
              count_d = cfg_data_i[bsp_pkg::CNT_BITS-1:0];
              state_d = ST_LA0;
            end
            bsp_pkg::CFG_BUFFER_FRAMES: begin
              frames_d = cfg_data_i[FB-1:0];
              state_d  = ST_LA0;
            end
            default: ;
          endcase
        end else if (in_valid_i) begin
          item_d = in_item_i;
          trig_d = in_item_i.op;
          idx_d  = in_item_i.target_segment;
          if (!in_item_i.op) begin
            req_d   = '{start: 1'b1, dividend: DW'(slice_q), divisor: DW'({slen_q, QB'(0)})};
            ret_d   = ST_W;
            state_d = ST_DIV;
          end else if ({1'b0, in_item_i.target_segment} < c_eff) begin
            state_d = ST_SEG;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ret_q;
        end
      end
      ST_LA0: begin
        req_d   = '{start: 1'b1, dividend: DW'(f_eff), divisor: DW'(c_eff)};
        ret_d   = ST_LA;
        state_d = ST_DIV;
      end
      ST_LA: begin
        seglen_d = (div_rsp_i.quotient == '0) ? FB'(1) : div_rsp_i.quotient[FB-1:0];
        slen_d   = seglen_d;
        play_d   = '0;
        slice_d  = '0;
        cur_d    = '0;
        start_d  = '0;
        if (c_eff == bsp_pkg::CNT_BITS'(1)) begin
          nb_d    = f_eff;
          state_d = ST_IDLE;
        end else begin
          req_d   = '{start: 1'b1, dividend: DW'({f_eff, 1'b0}) + DW'(c_eff),
                      divisor: off_divisor};
          ret_d   = ST_LB;
          state_d = ST_DIV;
        end
      end
      ST_LB: begin
        nb_d    = div_rsp_i.quotient[FB-1:0];
        state_d = ST_IDLE;
      end
      ST_W: begin
        w_d     = div_rsp_i.remainder[PB-1:0];
        prod_d  = bsp_pkg::PROD_BITS'(duty_q * slen_q);
        state_d = ST_GATE;
      end
      ST_GATE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.gate_on           = gate;
          out_d.segment_now       = cur_q;
          out_d.read_address      = gate ? addr_sum[FB-1:0] : '0;
          out_d.read_fraction     = gate ? w_q[QB-1:0] : '0;
          prod_d  = bsp_pkg::PROD_BITS'(item_q.play_rate * speed_q);
          sum_d   = {1'b0, play_q} + (PB+1)'(item_q.play_rate);
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        slice_d = slice_sum[PB] ? '1 : slice_sum[PB-1:0];
        if (sum_q >= (PB+1)'({nb_q, QB'(0)})) begin
          idx_d   = ({1'b0, cur_q} + 1'b1 >= c_eff) ? '0 : cur_q + 1'b1;
          state_d = ST_SEG;
        end else begin
          state_d = ST_PMOD;
        end
      end
      ST_PMOD: begin
        req_d   = '{start: 1'b1, dividend: sum_q, divisor: DW'({f_eff, QB'(0)})};
        ret_d   = ST_PFIN;
        state_d = ST_DIV;
      end
      ST_PFIN: begin
        play_d  = div_rsp_i.remainder[PB-1:0];
        state_d = ST_IDLE;
      end
      ST_SEG: begin
        cur_d   = idx_q;
        slice_d = '0;
        speed_d = item_q.segment_speed;
        duty_d  = item_q.duty;
        prod_d  = bsp_pkg::PROD_BITS'((do_jump ? tgt : idx_q) * f_eff);
        state_d = ST_SA;
      end
      ST_SA: begin
        req_d   = '{start: 1'b1, dividend: off_dividend, divisor: off_divisor};
        ret_d   = ST_SB;
        state_d = ST_DIV;
      end
      ST_SB: begin
        start_d = div_rsp_i.quotient[FB-1:0];
        if ({1'b0, idx_q} + 1'b1 >= c_eff) begin
          nb_d    = f_eff;
          state_d = ST_SD;
        end else begin
          prod_d  = bsp_pkg::PROD_BITS'((idx_q + 1'b1) * f_eff);
          state_d = ST_SC;
        end
      end
      ST_SC: begin
        req_d   = '{start: 1'b1, dividend: off_dividend, divisor: off_divisor};
        ret_d   = ST_SCD;
        state_d = ST_DIV;
      end
      ST_SCD: begin
        nb_d    = div_rsp_i.quotient[FB-1:0];
        state_d = ST_SD;
      end
      ST_SD: begin
        if (do_stut) begin
          req_d   = '{start: 1'b1, dividend: DW'({seglen_q, 8'd0}), divisor: DW'(divr)};
          ret_d   = ST_SE;
          state_d = ST_DIV;
        end else begin
          slen_d  = seglen_q;
          state_d = ST_SF;
        end
      end
      ST_SE: begin
        slen_d  = (div_rsp_i.quotient == '0) ? FB'(1) : div_rsp_i.quotient[FB-1:0];
        state_d = ST_SF;
      end
      ST_SF: begin
        if (trig_q) begin
          play_d  = {start_q, QB'(0)};
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PMOD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      req_q       <= '0;
      item_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= bsp_pkg::CNT_BITS'(bsp_pkg::RST_COUNT);
      frames_q    <= FB'(bsp_pkg::RST_FRAMES);
      play_q      <= '0;
      slice_q     <= '0;
      w_q         <= '0;
      sum_q       <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      trig_q      <= 1'b0;
      start_q     <= '0;
      nb_q        <= FB'(bsp_pkg::RST_NB);
      slen_q      <= FB'(bsp_pkg::RST_SEGLEN);
      seglen_q    <= FB'(bsp_pkg::RST_SEGLEN);
      speed_q     <= bsp_pkg::RATE_BITS'(bsp_pkg::ONE_FX);
      duty_q      <= bsp_pkg::DUTY_BITS'(bsp_pkg::ONE_FX);
      prod_q      <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      req_q       <= req_d;
      item_q      <= item_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      frames_q    <= frames_d;
      play_q      <= play_d;
      slice_q     <= slice_d;
      w_q         <= w_d;
      sum_q       <= sum_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      trig_q      <= trig_d;
      start_q     <= start_d;
      nb_q        <= nb_d;
      slen_q      <= slen_d;
      seglen_q    <= seglen_d;
      speed_q     <= speed_d;
      duty_q      <= duty_d;
      prod_q      <= prod_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign div_req_o   = req_q;

endmodule

[hdl/beat_slice_player_unit.sv]
// Each request is one audio frame: an advance request returns one result with the read
// address, fraction, gate and segment index, and a play trigger returns none. Everything
// runs through one shared 41-step restoring divider, and the next request is taken only
// after an advance, a play trigger or a configuration write has finished; an advance also
// waits while the result output is stalled.
module beat_slice_player_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsp_in_if.sink     in_i,
  bsp_cfg_if.sink    cfg_i,
  bsp_out_if.source  out_o
);

  bsp_pkg::div_req_t div_req;
  bsp_pkg::div_rsp_t div_rsp;

  bsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_i.item),
    .in_ready_o  (in_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.item),
    .out_ready_i (out_o.ready),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  bsp_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

[hdl/bsp_checker.sv]
module bsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_op_i,
  input logic               cfg_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bsp_pkg::out_item_t out_item_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  a_gate_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.gate_on |->
      out_item_i.read_address == '0 && out_item_i.read_fraction == '0)
    else $error("silent result carries an address");

  a_busy_after_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_op_i |=> !in_ready_i && !cfg_ready_i)
    else $error("ready while an advance request is in work");

  a_ready_implies_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> cfg_ready_i)
    else $error("request ready while configuration is blocked");

endmodule

bind beat_slice_player_unit bsp_checker u_bsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.item.op),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);
